// File: src/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types, constants and helpers for the daily usage window counter.
// ----------------------------------------------------------------------------
package dwc_pkg;

  // Field widths
  localparam int DAY_W  = 47;
  localparam int CNT_W  = 64;
  localparam int TIME_W = 64;
  localparam int USE_W  = 6;

  // Day table: depth equals the retention window, a power of two
  localparam int RETAIN_DAYS = 32;
  localparam int IDX_W       = $clog2(RETAIN_DAYS);

  // Day divider: t / 86400 = (t >> 7) / 675, taken 14 quotient bits at a time.
  // Each digit comes from a reciprocal multiply of {remainder, next 14 bits},
  // which stays below 675 * 2^14, where the reciprocal below is exact.
  localparam int                 DAY_SHIFT   = 7;
  localparam int                 DVD_W       = TIME_W - 1 - DAY_SHIFT;
  localparam int                 CHUNK_W     = 14;
  localparam int                 N_CHUNKS    = DVD_W / CHUNK_W;
  localparam int                 REM_W       = 10;
  localparam int                 PART_W      = REM_W + CHUNK_W;
  localparam logic [REM_W-1:0]   DAY_ODD     = 10'd675;
  localparam int                 RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP       = 27'd101806633;
  localparam int                 RECIP_SHIFT = 36;
  localparam int                 PROD_W      = PART_W + RECIP_W;
  localparam int                 STEP_W      = $clog2(2 * N_CHUNKS);
  localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(2 * N_CHUNKS - 1);

  localparam logic STATUS_RECORDED = 1'b0;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [CNT_W-1:0] prompt;
    logic [CNT_W-1:0] output_cnt;
    logic [CNT_W-1:0] requests;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic scan_init;
    logic scan_step;
    logic commit;
  } dwc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_done;
  } dwc_status_t;

  function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// File: src/dwc_if.sv
// ----------------------------------------------------------------------------
// dwc_if
// Valid/ready channels for usage records and counter results.
// ----------------------------------------------------------------------------
interface dwc_in_if import dwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_seconds;
  logic [CNT_W-1:0]  prompt_count;
  logic [CNT_W-1:0]  output_count;

  modport source (output valid, time_seconds, prompt_count, output_count, input ready);
  modport sink   (input valid, time_seconds, prompt_count, output_count, output ready);
endinterface

interface dwc_out_if import dwc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [DAY_W-1:0] day_number;
  logic [CNT_W-1:0] day_prompt_total;
  logic [CNT_W-1:0] day_output_total;
  logic [CNT_W-1:0] day_request_total;
  logic [CNT_W-1:0] window_prompt_total;
  logic [CNT_W-1:0] window_output_total;
  logic [CNT_W-1:0] window_request_total;
  logic [USE_W-1:0] days_in_use;

  modport source (output valid, status, day_number, day_prompt_total, day_output_total,
                  day_request_total, window_prompt_total, window_output_total,
                  window_request_total, days_in_use, input ready);
  modport sink   (input valid, status, day_number, day_prompt_total, day_output_total,
                  day_request_total, window_prompt_total, window_output_total,
                  window_request_total, days_in_use, output ready);
endinterface

// File: src/dwc_ctrl.sv
// ----------------------------------------------------------------------------
// dwc_ctrl
// Sequencer: divide, scan the day table, commit, hand off the result.
// ----------------------------------------------------------------------------
module dwc_ctrl import dwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  dwc_status_t status,
  output dwc_cmd_t    cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIVIDE;
      ST_DIVIDE: if (status.div_last) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_done) state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_DIVIDE: cmd.div_step  = 1'b1;
      ST_SETUP:  cmd.scan_init = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_COMMIT: cmd.commit    = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: src/dwc_dp.sv
// ----------------------------------------------------------------------------
// dwc_dp
// Datapath: multi-cycle day divider, circular day table, scan accumulators
// and the result register.
// ----------------------------------------------------------------------------
module dwc_dp import dwc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dwc_cmd_t          cmd,
  output dwc_status_t       status,
  input  logic [TIME_W-1:0] time_seconds,
  input  logic [CNT_W-1:0]  prompt_count,
  input  logic [CNT_W-1:0]  output_count,
  output logic [DAY_W-1:0]  day_number,
  output logic [CNT_W-1:0]  day_prompt_total,
  output logic [CNT_W-1:0]  day_output_total,
  output logic [CNT_W-1:0]  day_request_total,
  output logic [CNT_W-1:0]  window_prompt_total,
  output logic [CNT_W-1:0]  window_output_total,
  output logic [CNT_W-1:0]  window_request_total,
  output logic [USE_W-1:0]  days_in_use
);

  // Day table, kept as a sorted run starting at head
  entry_t mem [RETAIN_DAYS];
  entry_t rd_data;
  logic   rd_valid;
  logic [IDX_W-1:0] head;
  logic [USE_W-1:0] count;

  // Request holding and divider
  logic [CNT_W-1:0]   req_prompt, req_output;
  logic [DVD_W-1:0]   dvd;
  logic [DAY_W-1:0]   quo;
  logic [REM_W-1:0]   rem;
  logic [STEP_W-1:0]  div_cnt;
  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] qdig;
  logic [DAY_W-1:0]   today, lowest;

  // Scan state
  logic [USE_W-1:0] rd_idx, drop_n, keep_n;
  logic             match;
  logic [CNT_W-1:0] old_p, old_o, old_r;
  logic [CNT_W-1:0] acc_p, acc_o, acc_r;
  logic             issue;
  logic             keep;

  // Commit values
  logic [CNT_W-1:0] new_p, new_o, new_r;
  logic [IDX_W-1:0] slot;
  entry_t           wr_entry;

  assign today = quo;
  assign part  = {rem, dvd[DVD_W-1 -: CHUNK_W]};
  assign qdig  = prod[RECIP_SHIFT +: CHUNK_W];
  assign status.div_last  = (div_cnt == DIV_LAST);
  assign issue  = cmd.scan_step && (rd_idx < count);
  assign status.scan_done = (rd_idx == count) && !rd_valid;
  assign keep   = (rd_data.day >= lowest) && (rd_data.day <= today);

  // Divide the positive timestamp by seconds per day, one quotient digit
  // at a time: multiply by the reciprocal, then take the remainder
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_prompt <= prompt_count;
      req_output <= output_count;
      rem        <= '0;
      div_cnt    <= '0;
      quo        <= '0;
      prod       <= '0;
      dvd        <= (time_seconds[TIME_W-1] || time_seconds == '0)
                    ? '0 : time_seconds[TIME_W-2:DAY_SHIFT];
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!div_cnt[0]) begin
        prod <= PROD_W'(part) * PROD_W'(RECIP);
      end else begin
        quo <= {quo[DAY_W-CHUNK_W-1:0], qdig};
        rem <= REM_W'(part - PART_W'(qdig) * PART_W'(DAY_ODD));
        dvd <= {dvd[DVD_W-CHUNK_W-1:0], CHUNK_W'(0)};
      end
    end
  end

  // Scan the table: count pruned prefix, kept run, and sum the kept days other than today
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      lowest   <= (today >= DAY_W'(RETAIN_DAYS - 1)) ? today - DAY_W'(RETAIN_DAYS - 1) : '0;
      rd_idx   <= '0;
      rd_valid <= 1'b0;
      drop_n   <= '0;
      keep_n   <= '0;
      match    <= 1'b0;
      old_p    <= '0;
      old_o    <= '0;
      old_r    <= '0;
      acc_p    <= '0;
      acc_o    <= '0;
      acc_r    <= '0;
    end else begin
      rd_valid <= issue;
      if (issue) rd_idx <= rd_idx + 1'b1;
      if (rd_valid) begin
        if (rd_data.day < lowest) drop_n <= drop_n + 1'b1;
        if (keep) begin
          keep_n <= keep_n + 1'b1;
          if (rd_data.day == today) begin
            match <= 1'b1;
            old_p <= rd_data.prompt;
            old_o <= rd_data.output_cnt;
            old_r <= rd_data.requests;
          end else begin
            acc_p <= add_sat(acc_p, rd_data.prompt);
            acc_o <= add_sat(acc_o, rd_data.output_cnt);
            acc_r <= add_sat(acc_r, rd_data.requests);
          end
        end
      end
    end
  end

  // Today's counters after the update; a new day starts from zero
  assign new_p = add_sat(old_p, req_prompt);
  assign new_o = add_sat(old_o, req_output);
  assign new_r = add_sat(old_r, CNT_W'(1));
  // Today is always the last kept day, or is appended right after it
  assign slot  = head + drop_n[IDX_W-1:0] + keep_n[IDX_W-1:0] - IDX_W'(match);
  assign wr_entry = '{day: today, prompt: new_p, output_cnt: new_o, requests: new_r};

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) mem[slot] <= wr_entry;
    rd_data <= mem[head + rd_idx[IDX_W-1:0]];
  end

  // Advance the window bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      head  <= head + drop_n[IDX_W-1:0];
      count <= match ? keep_n : keep_n + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      day_number           <= today;
      day_prompt_total     <= new_p;
      day_output_total     <= new_o;
      day_request_total    <= new_r;
      window_prompt_total  <= add_sat(acc_p, new_p);
      window_output_total  <= add_sat(acc_o, new_o);
      window_request_total <= add_sat(acc_r, new_r);
      days_in_use          <= match ? keep_n : keep_n + 1'b1;
    end
  end

endmodule

// File: src/daily_usage_window_counter_core.sv
// ----------------------------------------------------------------------------
// daily_usage_window_counter_core
// Per-day saturating token and request counters over a sliding day window.
// ----------------------------------------------------------------------------
// Each request goes through the division of the timestamp by 86400 (four
// 14-bit quotient digits, each a reciprocal multiply followed by a remainder
// step), a scan setup step, a scan that reads each held day (up to 32) from
// the table through its single read port, then a drain, and a commit. A
// waiting result adds its stall to the commit. The table is a circular
// buffer of RETAIN_DAYS days, so pruning old days moves a pointer instead of
// copying entries. The result sits in an output register, so the next request
// is taken while it waits. Today is always the newest retained day, so a
// record is always counted and status is always 0.
module daily_usage_window_counter_core import dwc_pkg::*; (
  input logic clk,
  input logic rst,
  dwc_in_if.sink    in_ch,
  dwc_out_if.source out_ch
);

  dwc_cmd_t    cmd;
  dwc_status_t status;

  dwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dwc_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .time_seconds         (in_ch.time_seconds),
    .prompt_count         (in_ch.prompt_count),
    .output_count         (in_ch.output_count),
    .day_number           (out_ch.day_number),
    .day_prompt_total     (out_ch.day_prompt_total),
    .day_output_total     (out_ch.day_output_total),
    .day_request_total    (out_ch.day_request_total),
    .window_prompt_total  (out_ch.window_prompt_total),
    .window_output_total  (out_ch.window_output_total),
    .window_request_total (out_ch.window_request_total),
    .days_in_use          (out_ch.days_in_use)
  );

  assign out_ch.status = STATUS_RECORDED;

endmodule
